// File: hdl/mmt_pkg.sv
`timescale 1ns / 1ps

package mmt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 32;
    localparam int LIMIT_W    = 32;
    localparam int WS_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;
    localparam logic [WS_W-1:0]    WS_RESET    = 11'd16;

    typedef struct packed {
        logic [DATA_W-1:0] error_sample;
        logic [STEP_W-1:0] step_index;
    } t_in;

    typedef struct packed {
        logic              mean_valid;
        logic [DATA_W-1:0] window_mean;
        logic              keep_going;
        logic [STEP_W-1:0] step_echo;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_SUB,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// File: hdl/mmt_ring.sv
`timescale 1ns / 1ps

module mmt_ring #(
    parameter int DEPTH  = mmt_pkg::MAX_WINDOW_DEF,
    parameter int DATA_W = mmt_pkg::DATA_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read at the write address returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mmt_div.sv
`timescale 1ns / 1ps

module mmt_div #(
    parameter int NUM_W = mmt_pkg::SAMPLE_WIDTH_DEF + mmt_pkg::WS_W,
    parameter int DEN_W = mmt_pkg::WS_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output mmt_pkg::t_div_status o_status,
    output logic [NUM_W-1:0]    o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             q_bit;

    // One restoring step: bring down the next dividend bit, try the divisor
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        q_bit = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quo         = r_quo;

endmodule

// File: hdl/moving_mean_threshold_unit.sv
`timescale 1ns / 1ps

// Sliding-window mean of squared-error samples (unsigned Q16.16) with a
// continue/stop flag. Each input transfer adds its sample to a running sum
// and stores it in a ring of MAX_WINDOW entries; once step_index reaches the
// window size, the sample that entered window_size steps earlier is dropped
// from the sum, the sum is divided by the window size (truncated, saturated
// to 32 bits) and keep_going becomes mean > error_limit. Each input gives
// exactly one output transfer; before the window fills, mean_valid and
// window_mean are 0 and keep_going repeats the last flag (1 after reset).
// A window size of 0 acts as 1, a size above MAX_WINDOW acts as MAX_WINDOW.
// The sum wraps at SAMPLE_WIDTH + 11 bits. Steps must run consecutively from
// 0 after reset, so that no ring entry is read before it is written. Items
// are taken one at a time; an item with a full window goes through the
// bit-serial divider, which produces one quotient bit per cycle, and an
// item without a mean skips the divider. The ring is a single memory
// written and read once per item. A finished result waits in
// the output register while the next input is already taken.
// Write error_limit (index 0) and window_size (index 1) only while idle.

module moving_mean_threshold_unit #(
    parameter int MAX_WINDOW   = mmt_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mmt_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mmt_pkg::t_in                       i_in,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mmt_pkg::t_out                      o_out,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [mmt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mmt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int HEAD_W = $clog2(MAX_WINDOW);
    localparam int SMP_W  = (SAMPLE_WIDTH < mmt_pkg::DATA_W) ? SAMPLE_WIDTH : mmt_pkg::DATA_W;
    localparam int SUM_W  = SAMPLE_WIDTH + mmt_pkg::WS_W;
    localparam int QX_W   = (SUM_W > mmt_pkg::DATA_W) ? SUM_W : mmt_pkg::DATA_W;
    localparam int WS_W   = mmt_pkg::WS_W;

    localparam logic [WS_W-1:0]   MAX_WS  = (MAX_WINDOW > (2 ** WS_W) - 1) ? '1
                                                                        : WS_W'(MAX_WINDOW);
    localparam logic [HEAD_W:0]   MAX_IDX = (HEAD_W + 1)'(MAX_WINDOW);
    localparam logic [HEAD_W-1:0] LAST_IDX = HEAD_W'(MAX_WINDOW - 1);
    localparam logic [QX_W-1:0]   MEAN_MAX = QX_W'({mmt_pkg::DATA_W{1'b1}});

    mmt_pkg::t_state r_state, n_state;

    logic [mmt_pkg::LIMIT_W-1:0] r_limit;
    logic [WS_W-1:0]             r_ws;
    logic [SMP_W-1:0]            r_sample;
    logic [mmt_pkg::STEP_W-1:0]  r_step;
    logic [HEAD_W-1:0]           r_head;
    logic [SUM_W-1:0]            r_sum;
    logic                        r_full;
    logic                        r_flag;
    logic                        r_out_valid;
    mmt_pkg::t_out               r_out;

    logic [WS_W-1:0]   ws_eff;
    logic [HEAD_W:0]   idx_gap;
    logic [HEAD_W:0]   idx_sum;
    logic [HEAD_W-1:0] old_idx;
    logic [SMP_W-1:0]  oldest;
    logic              in_xfer;
    logic              out_load;
    logic              div_start;
    logic [SUM_W-1:0]  quo;
    logic [QX_W-1:0]   quo_ext;
    logic [mmt_pkg::DATA_W-1:0] mean;
    logic              over_limit;
    mmt_pkg::t_div_status div_stat;

    // Clamp the window size to the ring depth; zero acts as one
    always_comb begin
        if (r_ws == '0) begin
            ws_eff = WS_W'(1);
        end else if (r_ws > MAX_WS) begin
            ws_eff = MAX_WS;
        end else begin
            ws_eff = r_ws;
        end
    end

    // Slot of the sample leaving the window: head - ws, wrapped at the depth
    always_comb begin
        idx_gap = MAX_IDX - (HEAD_W + 1)'(ws_eff);
        idx_sum = {1'b0, r_head} + idx_gap;
        if (idx_sum >= MAX_IDX) begin
            old_idx = HEAD_W'(idx_sum - MAX_IDX);
        end else begin
            old_idx = idx_sum[HEAD_W-1:0];
        end
    end

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_load = !r_out_valid || i_out_ready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            mmt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = mmt_pkg::S_RING;
                end
            end
            mmt_pkg::S_RING: begin
                n_state = mmt_pkg::S_SUB;
            end
            mmt_pkg::S_SUB: begin
                n_state = r_full ? mmt_pkg::S_START : mmt_pkg::S_OUT;
            end
            mmt_pkg::S_START: begin
                div_start = 1'b1;
                n_state   = mmt_pkg::S_DIV;
            end
            mmt_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = mmt_pkg::S_OUT;
                end
            end
            mmt_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = mmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmt_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mmt_pkg::LIMIT_RESET;
            r_ws    <= mmt_pkg::WS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mmt_pkg::REG_ERROR_LIMIT: r_limit <= i_cfg_wdata[mmt_pkg::LIMIT_W-1:0];
                mmt_pkg::REG_WINDOW_SIZE: r_ws    <= i_cfg_wdata[WS_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_in.error_sample[SMP_W-1:0];
            r_step   <= i_in.step_index;
        end
    end

    // Ring: store the new sample at head, fetch the leaving one in the same cycle
    mmt_ring #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (SMP_W),
        .ADDR_W (HEAD_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == mmt_pkg::S_RING),
        .i_waddr (r_head),
        .i_wdata (r_sample),
        .i_re    (r_state == mmt_pkg::S_RING),
        .i_raddr (old_idx),
        .o_rdata (oldest)
    );

    // Head, running sum, window-full flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_sum  <= '0;
            r_full <= 1'b0;
        end else begin
            if (r_state == mmt_pkg::S_RING) begin
                r_head <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_sum  <= r_sum + SUM_W'(r_sample);
                r_full <= (r_step >= mmt_pkg::STEP_W'(ws_eff));
            end else if (r_state == mmt_pkg::S_SUB && r_full) begin
                // drop the oldest sample; the sum wraps
                r_sum <= r_sum - SUM_W'(oldest);
            end
        end
    end

    mmt_div #(
        .NUM_W (SUM_W),
        .DEN_W (WS_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_sum),
        .i_den    (ws_eff),
        .o_status (div_stat),
        .o_quo    (quo)
    );

    // Saturate the quotient to 32 bits and test it against the limit
    always_comb begin
        quo_ext    = QX_W'(quo);
        mean       = (quo_ext > MEAN_MAX) ? '1 : quo_ext[mmt_pkg::DATA_W-1:0];
        over_limit = (mean > r_limit);
    end

    // Continue flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b1;
        end else if (r_state == mmt_pkg::S_OUT && out_load && r_full) begin
            r_flag <= over_limit;
        end
    end

    // Output register: load when the slot is free, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mmt_pkg::S_OUT && out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mmt_pkg::S_OUT && out_load) begin
            r_out.mean_valid  <= r_full;
            r_out.window_mean <= r_full ? mean : '0;
            r_out.keep_going  <= r_full ? over_limit : r_flag;
            r_out.step_echo   <= r_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == mmt_pkg::S_DIV))
        else $error("divider busy outside its wait state");

    // An accepted item always goes to the ring step next
    a_accept_to_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == mmt_pkg::S_RING))
        else $error("accepted item did not advance to ring access");

    // A result without a mean carries a zero mean
    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.mean_valid) |-> (o_out.window_mean == '0))
        else $error("nonzero mean on a result without a full window");

    // Loading a result always leaves the output slot full
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmt_pkg::S_OUT && out_load) |=> o_out_valid)
        else $error("result load lost");

endmodule
